// ----- rtl/core/mscd_pkg.sv -----
package mscd_pkg;

  // octet 0 sits at index 0, the most significant byte of the flat vector
  typedef logic [0:9][7:0] octs_t;
  typedef logic [6:0]      bpos_t;
  typedef logic [4:0]      class_t;
  typedef logic [3:0]      caps_t;

  localparam int unsigned NumBits = 80;

  // item after the layout tree: classes and bit position of the dtm/8psk group
  typedef struct packed {
    octs_t  octs;
    class_t gprs;
    class_t egprs;
    bpos_t  pos;
  } lay_t;

  // item after the second tree: start of the four capability bits
  typedef struct packed {
    octs_t  octs;
    class_t gprs;
    class_t egprs;
    bpos_t  start;
  } sel_t;

  function automatic bpos_t bpos(input int unsigned o, input int unsigned b);
    return bpos_t'(o * 8 + b);
  endfunction

  // bit positions count from the msb of octet 0 and wrap at the element length
  function automatic logic bit_at(input octs_t d, input bpos_t pos);
    logic [NumBits-1:0] flat;
    bpos_t              q;
    flat = d;
    q = (pos >= bpos_t'(NumBits)) ? pos - bpos_t'(NumBits) : pos;
    return flat[bpos_t'(NumBits - 1) - q];
  endfunction

  function automatic lay_t decode_layout(input octs_t d);
    class_t g;
    class_t e;
    bpos_t  p;
    lay_t   r;
    g = '0;
    e = '0;
    p = '0;
    if (d[1][1]) begin
      if (d[3][5]) begin
        if (d[3][4]) begin
          if (d[4][6]) begin
            g = d[4][5:1];
            if (d[5][7]) begin
              if (d[6][6]) begin
                if (d[6][0]) begin e = d[7][7:3]; p = bpos(7, 6); end
                else p = bpos(7, 0);
              end else begin
                if (d[6][5]) begin e = d[6][4:0]; p = bpos(7, 1); end
                else p = bpos(6, 3);
              end
            end else begin
              if (d[5][6]) begin
                if (d[5][0]) begin e = d[6][7:3]; p = bpos(6, 6); end
                else p = bpos(6, 0);
              end else begin
                if (d[5][5]) begin e = d[5][4:0]; p = bpos(6, 1); end
                else p = bpos(5, 3);
              end
            end
          end else begin
            if (d[4][5]) begin
              if (d[5][4]) begin
                if (d[6][6]) begin e = d[6][5:1]; p = bpos(7, 0); end
                else p = bpos(6, 2);
              end else begin
                if (d[5][3]) begin e = {d[5][2:0], d[6][7:6]}; p = bpos(6, 3); end
                else p = bpos(5, 5);
              end
            end else begin
              if (d[4][4]) begin
                if (d[5][6]) begin e = d[5][5:1]; p = bpos(6, 0); end
                else p = bpos(5, 2);
              end else begin
                if (d[4][3]) begin e = {d[4][2:0], d[5][7:6]}; p = bpos(5, 3); end
                else p = bpos(4, 5);
              end
            end
          end
        end else begin
          if (d[3][3]) begin
            g = {d[3][2:0], d[4][7:6]};
            if (d[4][4]) begin
              if (d[5][3]) begin
                if (d[6][5]) begin e = d[6][4:0]; p = bpos(7, 1); end
                else p = bpos(6, 3);
              end else begin
                if (d[5][2]) begin e = {d[5][1:0], d[6][7:5]}; p = bpos(6, 4); end
                else p = bpos(5, 6);
              end
            end else begin
              if (d[4][3]) begin
                if (d[5][5]) begin e = d[5][4:0]; p = bpos(6, 1); end
                else p = bpos(5, 3);
              end else begin
                if (d[4][2]) begin e = {d[4][1:0], d[5][7:5]}; p = bpos(5, 4); end
                else p = bpos(4, 6);
              end
            end
          end else begin
            // repeats the gprs presence test just taken false: never true
            if (d[3][3]) begin
              if (d[4][2]) begin
                if (d[5][4]) begin e = {d[5][2:0], d[6][7:6]}; p = bpos(6, 2); end
                else p = bpos(5, 4);
              end else begin
                if (d[4][1]) begin e = {d[4][0], d[5][7:4]}; p = bpos(5, 5); end
                else p = bpos(4, 7);
              end
            end else begin
              if (d[3][2]) begin
                if (d[4][4]) begin e = {d[4][2:0], d[5][7:6]}; p = bpos(5, 2); end
                else p = bpos(4, 4);
              end else begin
                if (d[3][1]) begin e = {d[3][0], d[4][7:4]}; p = bpos(4, 5); end
                else p = bpos(3, 7);
              end
            end
          end
        end
      end else begin
        p = bpos(3, 3);
      end
    end else begin
      if (d[2][4]) begin
        if (d[2][3]) begin
          if (d[3][5]) begin
            g = d[3][4:0];
            if (d[4][6]) begin
              if (d[5][5]) begin
                if (d[6][7]) begin e = d[6][6:2]; p = bpos(6, 7); end
                else p = bpos(6, 1);
              end else begin
                if (d[5][4]) begin e = {d[5][3:0], d[6][7]}; p = bpos(6, 2); end
                else p = bpos(5, 4);
              end
            end else begin
              if (d[4][5]) begin
                if (d[5][7]) begin e = d[5][6:2]; p = bpos(5, 7); end
                else p = bpos(5, 1);
              end else begin
                if (d[4][4]) begin e = {d[4][3:0], d[5][7]}; p = bpos(5, 2); end
                else p = bpos(4, 4);
              end
            end
          end else begin
            if (d[3][4]) begin
              if (d[4][3]) begin
                if (d[5][5]) begin e = d[5][4:0]; p = bpos(6, 1); end
                else p = bpos(5, 3);
              end else begin
                if (d[4][2]) begin e = {d[4][1:0], d[5][7:5]}; p = bpos(5, 4); end
                else p = bpos(4, 6);
              end
            end else begin
              if (d[3][3]) begin
                if (d[4][5]) begin e = d[4][4:0]; p = bpos(5, 1); end
                else p = bpos(4, 3);
              end else begin
                if (d[3][2]) begin e = {d[3][1:0], d[4][7:5]}; p = bpos(4, 4); end
                else p = bpos(3, 6);
              end
            end
          end
        end else begin
          if (d[2][2]) begin
            g = {d[2][1:0], d[3][7:5]};
            if (d[3][3]) begin
              if (d[4][2]) begin
                if (d[5][4]) begin e = {d[5][3:0], d[6][7]}; p = bpos(6, 2); end
                else p = bpos(5, 4);
              end else begin
                if (d[4][1]) begin e = {d[4][0], d[5][7:4]}; p = bpos(5, 5); end
                else p = bpos(4, 7);
              end
            end else begin
              if (d[3][2]) begin
                if (d[4][4]) begin e = {d[4][3:0], d[5][7]}; p = bpos(5, 2); end
                else p = bpos(4, 4);
              end else begin
                if (d[3][1]) begin e = {d[3][0], d[4][7:4]}; p = bpos(4, 5); end
                else p = bpos(3, 7);
              end
            end
          end else begin
            // repeats the gprs presence test just taken false: never true
            if (d[2][2]) begin
              if (d[3][1]) begin
                if (d[4][3]) begin e = {d[4][1:0], d[5][7:5]}; p = bpos(5, 3); end
                else p = bpos(4, 5);
              end else begin
                if (d[3][0]) begin e = d[4][7:3]; p = bpos(4, 6); end
                else p = bpos(4, 0);
              end
            end else begin
              if (d[2][1]) begin
                if (d[3][3]) begin e = {d[3][1:0], d[4][7:5]}; p = bpos(4, 3); end
                else p = bpos(3, 5);
              end else begin
                if (d[2][0]) begin e = d[4][7:3]; p = bpos(3, 6); end
                else p = bpos(3, 0);
              end
            end
          end
        end
      end else begin
        p = bpos(2, 4);
      end
    end
    r.octs  = d;
    r.gprs  = g;
    r.egprs = e;
    r.pos   = p;
    return r;
  endfunction

endpackage

// ----- rtl/core/mscd_in_if.sv -----
interface mscd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] head_octets;
  logic [15:0] tail_octets;

  modport source (output valid, output head_octets, output tail_octets, input ready);
  modport sink   (input valid, input head_octets, input tail_octets, output ready);
endinterface

// ----- rtl/core/mscd_out_if.sv -----
interface mscd_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] gprs_class;
  logic [4:0] egprs_class;
  logic [3:0] radio_caps;

  modport source (output valid, output gprs_class, output egprs_class, output radio_caps,
                  input ready);
  modport sink   (input valid, input gprs_class, input egprs_class, input radio_caps,
                  output ready);
endinterface

// ----- rtl/core/multislot_capability_decode.sv -----
// channel | dir | payload                                  | handshake
// in_i    | in  | head_octets[63:0], tail_octets[15:0]     | valid/ready
// out_o   | out | gprs_class[4:0], egprs_class[4:0],       | valid/ready
//         |     | radio_caps[3:0]                          |
//
// one item per cycle while out_o.ready keeps the pipeline moving
// stages: layout tree, dtm/8psk offset tree, capability bit select
// each stage holds its item until the next stage takes it; ready ripples back
// from out_o.ready, so a full pipeline stalls in_i only while out_o is held
// rst_ni clears the stage valid bits only; the stage data registers are not reset
module multislot_capability_decode (
  input  logic   clk_i,
  input  logic   rst_ni,
  mscd_in_if.sink    in_i,
  mscd_out_if.source out_o
);

  logic             lay_valid, lay_ready;
  mscd_pkg::lay_t   lay;
  logic             sel_valid, sel_ready;
  mscd_pkg::sel_t   sel;
  logic             in_ready;

  mscd_layout u_layout (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .octs_i  (mscd_pkg::octs_t'({in_i.head_octets, in_i.tail_octets})),
    .ready_o (in_ready),
    .valid_o (lay_valid),
    .lay_o   (lay),
    .ready_i (lay_ready)
  );

  mscd_offset u_offset (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lay_valid),
    .lay_i   (lay),
    .ready_o (lay_ready),
    .valid_o (sel_valid),
    .sel_o   (sel),
    .ready_i (sel_ready)
  );

  mscd_caps u_caps (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sel_valid),
    .sel_i   (sel),
    .ready_o (sel_ready),
    .valid_o (out_o.valid),
    .gprs_o  (out_o.gprs_class),
    .egprs_o (out_o.egprs_class),
    .caps_o  (out_o.radio_caps),
    .ready_i (out_o.ready)
  );

  assign in_i.ready = in_ready;

endmodule

// ----- rtl/core/mscd_layout.sv -----
module mscd_layout (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  mscd_pkg::octs_t      octs_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output mscd_pkg::lay_t       lay_o,
  input  logic                 ready_i
);

  logic           valid_q;
  mscd_pkg::lay_t lay_d, lay_q;

  assign ready_o = !valid_q || ready_i;
  assign lay_d   = mscd_pkg::decode_layout(octs_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      lay_q <= lay_d;
    end
  end

  assign valid_o = valid_q;
  assign lay_o   = lay_q;

endmodule

// ----- rtl/core/mscd_offset.sv -----
module mscd_offset (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  mscd_pkg::lay_t       lay_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output mscd_pkg::sel_t       sel_o,
  input  logic                 ready_i
);

  logic            valid_q;
  mscd_pkg::sel_t  sel_d, sel_q;
  mscd_pkg::bpos_t p;

  assign ready_o = !valid_q || ready_i;
  assign p       = lay_i.pos;

  // skip dtm gprs/egprs classes and 8psk power capability when present
  always_comb begin
    sel_d.octs  = lay_i.octs;
    sel_d.gprs  = lay_i.gprs;
    sel_d.egprs = lay_i.egprs;
    if (mscd_pkg::bit_at(lay_i.octs, p)) begin
      if (mscd_pkg::bit_at(lay_i.octs, p + 7'd4)) begin
        sel_d.start = mscd_pkg::bit_at(lay_i.octs, p + 7'd7) ? p + 7'd12 : p + 7'd10;
      end else begin
        sel_d.start = mscd_pkg::bit_at(lay_i.octs, p + 7'd5) ? p + 7'd10 : p + 7'd8;
      end
    end else begin
      sel_d.start = mscd_pkg::bit_at(lay_i.octs, p + 7'd1) ? p + 7'd6 : p + 7'd4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      sel_q <= sel_d;
    end
  end

  assign valid_o = valid_q;
  assign sel_o   = sel_q;

endmodule

// ----- rtl/core/mscd_caps.sv -----
module mscd_caps (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  mscd_pkg::sel_t       sel_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output mscd_pkg::class_t     gprs_o,
  output mscd_pkg::class_t     egprs_o,
  output mscd_pkg::caps_t      caps_o,
  input  logic                 ready_i
);

  logic             valid_q;
  mscd_pkg::class_t gprs_q, egprs_q;
  mscd_pkg::caps_t  caps_d, caps_q;
  mscd_pkg::bpos_t  s;

  assign ready_o = !valid_q || ready_i;
  assign s       = sel_i.start;
  assign caps_d  = {mscd_pkg::bit_at(sel_i.octs, s + 7'd3),
                    mscd_pkg::bit_at(sel_i.octs, s + 7'd2),
                    mscd_pkg::bit_at(sel_i.octs, s + 7'd1),
                    mscd_pkg::bit_at(sel_i.octs, s)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      gprs_q  <= sel_i.gprs;
      egprs_q <= sel_i.egprs;
      caps_q  <= caps_d;
    end
  end

  assign valid_o = valid_q;
  assign gprs_o  = gprs_q;
  assign egprs_o = egprs_q;
  assign caps_o  = caps_q;

endmodule

// ----- rtl/core/mscd_checker.sv -----
module mscd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [4:0] gprs_i,
  input logic [4:0] egprs_i,
  input logic [3:0] caps_i
);

  // items accepted but not yet delivered
  logic [1:0] fill_q, fill_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    fill_d = fill_q;
    if (in_acc && !out_acc) begin
      fill_d = fill_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(gprs_i) && $stable(egprs_i)
                                    && $stable(caps_i))
    else $error("result changed while stalled");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("item not delivered three cycles after acceptance");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> fill_q != 2'd0)
    else $error("result without an item in flight");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> fill_q == 2'd3 && out_valid_i)
    else $error("input stalled with room in the pipeline");

  a_empty_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output stage empty");

endmodule

bind multislot_capability_decode mscd_checker u_mscd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .gprs_i      (out_o.gprs_class),
  .egprs_i     (out_o.egprs_class),
  .caps_i      (out_o.radio_caps)
);

// ----- tb/mscd_tb_pkg.sv -----
package mscd_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    mscd_pkg::class_t gprs;
    mscd_pkg::class_t egprs;
    mscd_pkg::caps_t  caps;
  } decode_t;

  // bit positions count from the msb of octet 0 and wrap at 80
  function automatic logic pb(input logic [79:0] el, input int unsigned pos);
    return el[79 - (pos % 80)];
  endfunction

  function automatic mscd_pkg::class_t fld(input logic [79:0] el, input int unsigned pos);
    mscd_pkg::class_t r;
    for (int k = 0; k < 5; k++) r[4-k] = pb(el, pos + k);
    return r;
  endfunction

  // egprs presence bit at q, class read at f, then dtm group at py or pn
  function automatic void egprs_leaf(input logic [79:0] el, input int unsigned q, f, py, pn,
                                     output mscd_pkg::class_t e, output int unsigned p);
    if (pb(el, q)) begin
      e = fld(el, f);
      p = py;
    end else begin
      e = '0;
      p = pn;
    end
  endfunction

  function automatic decode_t predict_decode(input logic [79:0] el);
    mscd_pkg::class_t g;
    mscd_pkg::class_t e;
    int unsigned      p;
    int unsigned      s;
    decode_t          r;
    g = '0;
    e = '0;
    p = 0;
    if (pb(el, 14)) begin
      if (!pb(el, 26)) p = 27;
      else if (pb(el, 27)) begin
        if (pb(el, 33)) begin
          g = fld(el, 34);
          if (pb(el, 40)) begin
            if (pb(el, 49)) egprs_leaf(el, 55, 56, 62, 56, e, p);
            else egprs_leaf(el, 50, 51, 57, 51, e, p);
          end else begin
            if (pb(el, 41)) egprs_leaf(el, 47, 48, 54, 48, e, p);
            else egprs_leaf(el, 42, 43, 49, 43, e, p);
          end
        end else begin
          if (pb(el, 34)) begin
            if (pb(el, 43)) egprs_leaf(el, 49, 50, 56, 50, e, p);
            else egprs_leaf(el, 44, 45, 51, 45, e, p);
          end else begin
            if (pb(el, 35)) egprs_leaf(el, 41, 42, 48, 42, e, p);
            else egprs_leaf(el, 36, 37, 43, 37, e, p);
          end
        end
      end else if (pb(el, 28)) begin
        g = fld(el, 29);
        if (pb(el, 35)) begin
          if (pb(el, 44)) egprs_leaf(el, 50, 51, 57, 51, e, p);
          else egprs_leaf(el, 45, 46, 52, 46, e, p);
        end else begin
          if (pb(el, 36)) egprs_leaf(el, 42, 43, 49, 43, e, p);
          else egprs_leaf(el, 37, 38, 44, 38, e, p);
        end
      end else if (pb(el, 28)) begin
        // sms test re-reads the gprs bit that just failed
        if (pb(el, 37)) egprs_leaf(el, 43, 45, 50, 44, e, p);
        else egprs_leaf(el, 38, 39, 45, 39, e, p);
      end else begin
        if (pb(el, 29)) egprs_leaf(el, 35, 37, 42, 36, e, p);
        else egprs_leaf(el, 30, 31, 37, 31, e, p);
      end
    end else begin
      if (!pb(el, 19)) p = 20;
      else if (pb(el, 20)) begin
        if (pb(el, 26)) begin
          g = fld(el, 27);
          if (pb(el, 33)) begin
            if (pb(el, 42)) egprs_leaf(el, 48, 49, 55, 49, e, p);
            else egprs_leaf(el, 43, 44, 50, 44, e, p);
          end else begin
            if (pb(el, 34)) egprs_leaf(el, 40, 41, 47, 41, e, p);
            else egprs_leaf(el, 35, 36, 42, 36, e, p);
          end
        end else begin
          if (pb(el, 27)) begin
            if (pb(el, 36)) egprs_leaf(el, 42, 43, 49, 43, e, p);
            else egprs_leaf(el, 37, 38, 44, 38, e, p);
          end else begin
            if (pb(el, 28)) egprs_leaf(el, 34, 35, 41, 35, e, p);
            else egprs_leaf(el, 29, 30, 36, 30, e, p);
          end
        end
      end else if (pb(el, 21)) begin
        g = fld(el, 22);
        if (pb(el, 28)) begin
          if (pb(el, 37)) egprs_leaf(el, 43, 44, 50, 44, e, p);
          else egprs_leaf(el, 38, 39, 45, 39, e, p);
        end else begin
          if (pb(el, 29)) egprs_leaf(el, 35, 36, 42, 36, e, p);
          else egprs_leaf(el, 30, 31, 37, 31, e, p);
        end
      end else if (pb(el, 21)) begin
        // same repeated gprs test as above
        if (pb(el, 30)) egprs_leaf(el, 36, 38, 43, 37, e, p);
        else egprs_leaf(el, 31, 32, 38, 32, e, p);
      end else begin
        if (pb(el, 22)) egprs_leaf(el, 28, 30, 35, 29, e, p);
        else egprs_leaf(el, 23, 32, 30, 24, e, p);
      end
    end
    // dtm gprs / dtm egprs / 8psk presence bits ahead of the rat bits
    if (pb(el, p)) begin
      if (pb(el, p + 4)) s = pb(el, p + 7) ? p + 12 : p + 10;
      else s = pb(el, p + 5) ? p + 10 : p + 8;
    end else begin
      s = pb(el, p + 1) ? p + 6 : p + 4;
    end
    r.gprs  = g;
    r.egprs = e;
    r.caps  = {pb(el, s + 3), pb(el, s + 2), pb(el, s + 1), pb(el, s)};
    return r;
  endfunction

  class capability_checker;
    decode_t     pending_decodes[$];
    int unsigned compared;
    int unsigned mismatches;

    function void note_element(input logic [79:0] el);
      pending_decodes.push_back(predict_decode(el));
    endfunction

    function void check_decode(input mscd_pkg::class_t g, input mscd_pkg::class_t e,
                               input mscd_pkg::caps_t c);
      decode_t want;
      compared++;
      if (pending_decodes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result gprs %0d egprs %0d caps %h", $time, g, e, c);
        return;
      end
      want = pending_decodes.pop_front();
      if (want.gprs !== g) begin
        mismatches++;
        $display("%0t: gprs_class expected %0d got %0d", $time, want.gprs, g);
      end
      if (want.egprs !== e) begin
        mismatches++;
        $display("%0t: egprs_class expected %0d got %0d", $time, want.egprs, e);
      end
      if (want.caps !== c) begin
        mismatches++;
        $display("%0t: radio_caps expected %h got %h", $time, want.caps, c);
      end
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 500;
  localparam int unsigned DrainCycles = 8;

  typedef enum int unsigned {
    LayFirstFull,
    LayFirstGprs,
    LayFirstNoGprs,
    LaySecondFull,
    LaySecondGprs,
    LaySecondNoGprs,
    LayNoMsFirst,
    LayNoMsSecond
  } layout_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mscd_in_if  in_bus ();
  mscd_out_if out_bus ();

  multislot_capability_decode u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  mscd_tb_pkg::capability_checker decodes = new();
  int unsigned       send_idle_pct  = 0;
  int unsigned       sink_stall_pct = 0;
  int unsigned       elems_sent     = 0;

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (out_bus.valid && out_bus.ready) begin
      decodes.check_decode(out_bus.gprs_class, out_bus.egprs_class, out_bus.radio_caps);
    end
    out_bus.ready <= rst_ni && ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic logic [79:0] rand_bits80();
    logic [95:0] w;
    w = {$urandom(), $urandom(), $urandom()};
    return w[79:0];
  endfunction

  // pin the presence bits that pick one branch of the layout tree
  function automatic logic [79:0] force_layout(input logic [79:0] el, input layout_e lay);
    case (lay)
      LayFirstFull: begin
        el[79-14] = 1'b1; el[79-26] = 1'b1; el[79-27] = 1'b1; el[79-33] = 1'b1;
      end
      LayFirstGprs: begin
        el[79-14] = 1'b1; el[79-26] = 1'b1; el[79-27] = 1'b0; el[79-28] = 1'b1;
      end
      LayFirstNoGprs: begin
        el[79-14] = 1'b1; el[79-26] = 1'b1; el[79-27] = 1'b0; el[79-28] = 1'b0;
      end
      LaySecondFull: begin
        el[79-14] = 1'b0; el[79-19] = 1'b1; el[79-20] = 1'b1; el[79-26] = 1'b1;
      end
      LaySecondGprs: begin
        el[79-14] = 1'b0; el[79-19] = 1'b1; el[79-20] = 1'b0; el[79-21] = 1'b1;
      end
      LaySecondNoGprs: begin
        el[79-14] = 1'b0; el[79-19] = 1'b1; el[79-20] = 1'b0; el[79-21] = 1'b0;
      end
      LayNoMsFirst: begin
        el[79-14] = 1'b1; el[79-26] = 1'b0;
      end
      default: begin
        el[79-14] = 1'b0; el[79-19] = 1'b0;
      end
    endcase
    return el;
  endfunction

  function automatic logic [79:0] random_elem();
    logic [79:0] a;
    logic [79:0] b;
    a = rand_bits80();
    b = rand_bits80();
    case ($urandom_range(9))
      6, 7:    return force_layout(a, layout_e'($urandom_range(LayNoMsSecond)));
      8:       return a & b;
      9:       return a | b;
      default: return a;
    endcase
  endfunction

  task automatic send_elem(input logic [79:0] el);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.head_octets <= el[79:16];
    in_bus.tail_octets <= el[15:0];
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    decodes.note_element(el);
    elems_sent++;
  endtask

  // hold off the sender until every decode has come back
  task automatic drain_decodes();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (decodes.pending_decodes.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_elem(random_elem());
  endtask

  initial begin
    int unsigned directed;
    in_bus.valid       <= 1'b0;
    in_bus.head_octets <= '0;
    in_bus.tail_octets <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 19;
    sink_stall_pct = 86;
    send_elem('0);
    send_elem('1);
    send_elem({10{8'hAA}});
    send_elem({10{8'h55}});
    for (int l = LayFirstFull; l <= LayNoMsSecond; l++) begin
      send_elem(force_layout(rand_bits80(), layout_e'(l)));
      send_elem(force_layout(rand_bits80(), layout_e'(l)));
    end
    directed = elems_sent;
    send_random(RandomItems / 3);
    drain_decodes();

    send_idle_pct  = 86;
    sink_stall_pct = 19;
    send_random(RandomItems / 3);
    drain_decodes();

    send_idle_pct  = 0;
    sink_stall_pct = 0;
    send_random(RandomItems - 2 * (RandomItems / 3));
    drain_decodes();
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d capability elements (%0d directed) under three idle/stall mixes",
             elems_sent, directed);
    $display("%0d decodes compared field by field, %0d field mismatches",
             decodes.compared, decodes.mismatches);
    if (decodes.mismatches == 0 && decodes.pending_decodes.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout waiting for decodes");
    $display("tb_top: errors");
    $finish;
  end

endmodule
